>>> src/tlsa_pkg.sv
// ----------------------------------------------------------------------------
// tlsa_pkg
// Shared types, codes and sizes for the slot owner allocator.
// ----------------------------------------------------------------------------
package tlsa_pkg;

    // Table geometry
    localparam int SLOT_COUNT = 128;
    localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // Field widths
    localparam int ADDR_W   = 32;
    localparam int ID_W     = 32;
    localparam int SIZE_W   = 24;
    localparam int STATUS_W = 3;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_BASE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_SIZE = CFG_IDX_W'(1);

    // Request modes
    localparam logic MODE_GET  = 1'b0;
    localparam logic MODE_FREE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_EXISTING  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CLAIMED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_INACTIVE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FREED     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_OWNED = 3'd5;

    // Channel payloads
    typedef struct packed {
        logic            mode;
        logic [ID_W-1:0] thread_id;
    } tlsa_in_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   slot_address;
        logic [STATUS_W-1:0] status;
    } tlsa_out_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_MUL,
        S_EMIT
    } tlsa_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;    // capture request, restart scan
        logic scan;    // issue one table read
        logic decide;  // resolve outcome, update table
        logic mul;     // form index times slot size
        logic emit;    // load result register
    } tlsa_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic last_issue;  // current read is the last table entry
        logic out_free;    // result register can take an item
    } tlsa_sts_t;

endpackage

>>> src/tlsa_ctrl.sv
// ----------------------------------------------------------------------------
// tlsa_ctrl
// Sequencer: accept a request, scan the table, resolve, compute address, emit.
// ----------------------------------------------------------------------------
module tlsa_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output tlsa_pkg::tlsa_cmd_t cmd,
    input  tlsa_pkg::tlsa_sts_t sts
);

    tlsa_pkg::tlsa_state_t state_reg;
    tlsa_pkg::tlsa_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tlsa_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tlsa_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = tlsa_pkg::S_SCAN;
                end
            end
            tlsa_pkg::S_SCAN: begin
                if (sts.last_issue) begin
                    state_next = tlsa_pkg::S_DRAIN;
                end
            end
            tlsa_pkg::S_DRAIN:  state_next = tlsa_pkg::S_DECIDE;
            tlsa_pkg::S_DECIDE: state_next = tlsa_pkg::S_MUL;
            tlsa_pkg::S_MUL:    state_next = tlsa_pkg::S_EMIT;
            tlsa_pkg::S_EMIT: begin
                if (sts.out_free) begin
                    state_next = tlsa_pkg::S_IDLE;
                end
            end
            default: state_next = tlsa_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            tlsa_pkg::S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            tlsa_pkg::S_SCAN:   cmd.scan   = 1'b1;
            tlsa_pkg::S_DRAIN:  cmd        = '0;
            tlsa_pkg::S_DECIDE: cmd.decide = 1'b1;
            tlsa_pkg::S_MUL:    cmd.mul    = 1'b1;
            tlsa_pkg::S_EMIT:   cmd.emit   = sts.out_free;
            default:            cmd        = '0;
        endcase
    end

endmodule

>>> src/tlsa_dpath.sv
// ----------------------------------------------------------------------------
// tlsa_dpath
// Owner table, scan compare, outcome logic, address arithmetic, result register.
// ----------------------------------------------------------------------------
module tlsa_dpath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  tlsa_pkg::tlsa_in_t                   s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output tlsa_pkg::tlsa_out_t                  m_data,
    input  logic                                 cfg_valid,
    input  logic [tlsa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tlsa_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  tlsa_pkg::tlsa_cmd_t                  cmd,
    output tlsa_pkg::tlsa_sts_t                  sts
);

    localparam int IW = tlsa_pkg::IDX_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(tlsa_pkg::SLOT_COUNT - 1);

    // Configuration
    logic [tlsa_pkg::ADDR_W-1:0] slot_base_reg;
    logic [tlsa_pkg::SIZE_W-1:0] slot_size_reg;

    // Request
    logic                      req_mode_reg;
    logic [tlsa_pkg::ID_W-1:0] req_id_reg;

    // Scan
    logic [IW-1:0]             scan_idx_reg;
    logic                      rd_valid_reg;
    logic [IW-1:0]             rd_idx_reg;
    logic [tlsa_pkg::ID_W-1:0] rd_data_reg;
    logic                      rd_vbit_reg;
    logic [tlsa_pkg::ID_W-1:0] entry;
    logic                      hit_found_reg;
    logic [IW-1:0]             hit_idx_reg;
    logic                      free_found_reg;
    logic [IW-1:0]             free_idx_reg;

    // Owner table
    logic [tlsa_pkg::ID_W-1:0]     mem [tlsa_pkg::SLOT_COUNT];
    logic [tlsa_pkg::SLOT_COUNT-1:0] valid_reg;

    // Outcome
    logic [tlsa_pkg::STATUS_W-1:0] dec_status;
    logic [IW-1:0]                 dec_idx;
    logic                          dec_has_addr;
    logic                          tbl_claim;
    logic                          tbl_free;
    logic [tlsa_pkg::STATUS_W-1:0] res_status_reg;
    logic [IW-1:0]                 res_idx_reg;
    logic                          res_has_addr_reg;
    logic [tlsa_pkg::ADDR_W-1:0]   prod_reg;

    // Result register
    logic                 m_valid_reg;
    tlsa_pkg::tlsa_out_t  m_data_reg;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_base_reg <= '0;
            slot_size_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == tlsa_pkg::REG_SLOT_BASE) begin
                slot_base_reg <= cfg_data;
            end else if (cfg_index == tlsa_pkg::REG_SLOT_SIZE) begin
                slot_size_reg <= cfg_data[tlsa_pkg::SIZE_W-1:0];
            end
        end
    end

    // Capture the request
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_mode_reg <= s_data.mode;
            req_id_reg   <= s_data.thread_id;
        end
    end

    // Advance the scan address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.scan;
            if (cmd.load) begin
                scan_idx_reg <= '0;
            end else if (cmd.scan) begin
                scan_idx_reg <= scan_idx_reg + IW'(1);
            end
        end
    end

    assign sts.last_issue = cmd.scan && (scan_idx_reg == LAST_IDX);

    // Table read port, registered
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[scan_idx_reg];
        rd_vbit_reg <= valid_reg[scan_idx_reg];
        rd_idx_reg  <= scan_idx_reg;
    end

    // Table write port: claim stores the owner id
    always_ff @(posedge aclk) begin
        if (tbl_claim) begin
            mem[dec_idx] <= req_id_reg;
        end
    end

    // Valid bits: an entry that is not valid reads as free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (tbl_claim) begin
            valid_reg[dec_idx] <= 1'b1;
        end else if (tbl_free) begin
            valid_reg[dec_idx] <= 1'b0;
        end
    end

    assign entry = rd_vbit_reg ? rd_data_reg : '0;

    // Track first owned slot and first free slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (cmd.load) begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (rd_valid_reg) begin
            if (!hit_found_reg && (entry == req_id_reg)) begin
                hit_found_reg <= 1'b1;
            end
            if (!free_found_reg && (entry == '0)) begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_valid_reg && !hit_found_reg && (entry == req_id_reg)) begin
            hit_idx_reg <= rd_idx_reg;
        end
        if (rd_valid_reg && !free_found_reg && (entry == '0)) begin
            free_idx_reg <= rd_idx_reg;
        end
    end

    // Resolve outcome of the scan
    always_comb begin
        dec_status   = tlsa_pkg::ST_INACTIVE;
        dec_idx      = hit_idx_reg;
        dec_has_addr = 1'b0;
        tbl_claim    = 1'b0;
        tbl_free     = 1'b0;
        if ((slot_size_reg == '0) || (req_id_reg == '0)) begin
            dec_status = tlsa_pkg::ST_INACTIVE;
        end else if (req_mode_reg == tlsa_pkg::MODE_GET) begin
            if (hit_found_reg) begin
                dec_status   = tlsa_pkg::ST_EXISTING;
                dec_has_addr = 1'b1;
            end else if (free_found_reg) begin
                dec_status   = tlsa_pkg::ST_CLAIMED;
                dec_idx      = free_idx_reg;
                dec_has_addr = 1'b1;
                tbl_claim    = cmd.decide;
            end else begin
                dec_status = tlsa_pkg::ST_FULL;
            end
        end else begin
            if (hit_found_reg) begin
                dec_status   = tlsa_pkg::ST_FREED;
                dec_has_addr = 1'b1;
                tbl_free     = cmd.decide;
            end else begin
                dec_status = tlsa_pkg::ST_NOT_OWNED;
            end
        end
    end

    // Hold the outcome, then multiply index by slot size
    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            res_status_reg   <= dec_status;
            res_idx_reg      <= dec_idx;
            res_has_addr_reg <= dec_has_addr;
        end
        if (cmd.mul) begin
            prod_reg <= tlsa_pkg::ADDR_W'(
                {{(tlsa_pkg::ADDR_W - IW){1'b0}}, res_idx_reg} *
                {{(tlsa_pkg::ADDR_W - tlsa_pkg::SIZE_W){1'b0}}, slot_size_reg});
        end
    end

    // Result register: load on emit, drop on take
    assign sts.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg.status       <= res_status_reg;
            m_data_reg.slot_address <= res_has_addr_reg ? (slot_base_reg + prod_reg) : '0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> src/tls_slot_owner_allocator_top.sv
// ----------------------------------------------------------------------------
// tls_slot_owner_allocator_top
// Thread slot allocator: owner lookup, lowest-free claim and release.
// ----------------------------------------------------------------------------
// Each request makes one pass over the owner table through its single
// registered read port, which finds the owned slot and the lowest free
// slot together, followed by outcome, multiply and address-add steps. The
// table needs no clearing pass after reset. s_ready is high only between
// requests; a finished result waits in the output register while the next
// request is accepted. Configuration writes are always accepted and must be
// issued only while no request is in flight.
module tls_slot_owner_allocator_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  tlsa_pkg::tlsa_in_t                   s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output tlsa_pkg::tlsa_out_t                  m_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tlsa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tlsa_pkg::CFG_DATA_W-1:0]      cfg_data
);

    tlsa_pkg::tlsa_cmd_t cmd;
    tlsa_pkg::tlsa_sts_t sts;

    assign cfg_ready = 1'b1;

    // Sequencer
    tlsa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // Table and arithmetic
    tlsa_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
